// ===== rtl/assert_macros.svh =====
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/pcpa_pkg.sv =====
package pcpa_pkg;

  localparam int ADDR_W   = 34;
  localparam int CPU_IN_W = 3;

  localparam int DEF_CPU_COUNT  = 8;
  localparam int DEF_PAGE_COUNT = 32768;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam logic [ADDR_W-1:0] DEF_REGION_START = 34'h0_8000_0000;
  localparam logic [ADDR_W-1:0] DEF_REGION_STOP  = 34'h0_8800_0000;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REGION_START = 1'b0;
  localparam cfg_idx_t CFG_REGION_STOP  = 1'b1;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_BAD_ADDR = 2'd1,
    RS_NO_MEM   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_LO,
    ST_FREE_HI,
    ST_FREE_IDX,
    ST_FREE_PUSH,
    ST_ALLOC_HEAD,
    ST_ALLOC_READ
  } state_e;

  typedef struct packed {
    logic                command;
    logic [CPU_IN_W-1:0] cpu;
    logic [ADDR_W-1:0]   page_addr;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] alloc_addr;
  } rsp_t;

  // Region start rounded up to the page size; one bit wider to hold the carry.
  function automatic logic [ADDR_W:0] page_round_up(logic [ADDR_W-1:0] a, int shift);
    logic [ADDR_W:0] m;
    m = ((ADDR_W+1)'(1) << shift) - (ADDR_W+1)'(1);
    return ({1'b0, a} + m) & ~m;
  endfunction

  // cpu modulo list count by repeated conditional subtraction, narrow operand
  function automatic logic [CPU_IN_W-1:0] cpu_mod(logic [CPU_IN_W-1:0] c, int n);
    logic [CPU_IN_W-1:0] v;
    v = c;
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= n) v = v - CPU_IN_W'(n);
    end
    return v;
  endfunction

endpackage

// ===== rtl/per_cpu_page_allocator.sv =====
// Per-CPU LIFO page allocator, lists linked through a next-link RAM.
// Request channel: req_i is taken at a rising edge with start high and busy
// low; busy stays high while the request is worked on.
// Result channel: rsp_o is valid for exactly one cycle with strobe_o high and
// is taken at the end of that cycle; there is no back-pressure.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Writes only while no request is in flight.
// Steps, from the accepting edge to the strobe cycle:
//   free: start and alignment check, stop check, index subtraction in the shared
//   add/compare unit, then push; it ends at the first check if misaligned or below
//   start, at the second if at or above stop, at the push if past the page count.
//   alloc, own list non-empty: head check plus next-link RAM read; stealing from
//   list k: own check, scan 0..k, read; out of memory: own check, scan of all lists.
// busy drops in the strobe cycle, so a new request may be taken there; the
// registered link RAM read and the single adder set these steps.
// Reset: every list empty, region registers back to their defaults, no
// clearing pass over the link RAM (an entry is only read once pushed).
`include "assert_macros.svh"

module per_cpu_page_allocator #(
  parameter int CPU_COUNT  = pcpa_pkg::DEF_CPU_COUNT,
  parameter int PAGE_COUNT = pcpa_pkg::DEF_PAGE_COUNT,
  parameter int PAGE_BYTES = pcpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  pcpa_pkg::req_t                  req_i,
  output logic                            strobe_o,
  output pcpa_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  pcpa_pkg::cfg_idx_t              cfg_index_i,
  input  logic [pcpa_pkg::ADDR_W-1:0]     cfg_data_i
);

  localparam int ADDR_W   = pcpa_pkg::ADDR_W;
  localparam int AU_W     = ADDR_W + 1;
  localparam int PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int LINK_W   = $clog2(PAGE_COUNT + 1);
  localparam int IDX_W    = $clog2(PAGE_COUNT);
  localparam int IDXF_W   = ADDR_W - PB_SHIFT;
  localparam int CPU_W    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  pcpa_pkg::state_e state_q, state_d;

  logic [ADDR_W-1:0] start_q, stop_q;
  logic [AU_W-1:0]   base_q;

  logic [CPU_W-1:0]  cpu_q, cpu_d;
  logic [CPU_W-1:0]  scan_q, scan_d;
  logic              own_q, own_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] diff_q, diff_d;
  logic [IDX_W-1:0]  page_q, page_d;
  pcpa_pkg::rsp_t    res_q, res_d;
  logic              strobe_q, strobe_d;

  logic [LINK_W-1:0] head_q [CPU_COUNT];
  logic              head_we;
  logic [LINK_W-1:0] head_wdata;
  logic [CPU_W-1:0]  sel;
  logic [LINK_W-1:0] head_cur;

  logic [LINK_W-1:0] link_mem [PAGE_COUNT];
  logic [LINK_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata;

  // shared add/subtract unit
  logic [AU_W-1:0] au_a, au_b, au_sum;
  logic            au_sub;

  logic [IDXF_W-1:0] idx_full;

  assign au_sum = au_a + (au_sub ? ~au_b : au_b) + AU_W'(au_sub);

  assign sel      = own_q ? cpu_q : scan_q;
  assign head_cur = head_q[sel];
  assign idx_full = diff_q[ADDR_W-1:PB_SHIFT];

  assign busy        = (state_q != pcpa_pkg::ST_IDLE);
  assign strobe_o    = strobe_q;
  assign rsp_o       = res_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    cpu_d      = cpu_q;
    scan_d     = scan_q;
    own_d      = own_q;
    addr_d     = addr_q;
    diff_d     = diff_q;
    page_d     = page_q;
    res_d      = res_q;
    strobe_d   = 1'b0;
    au_a       = '0;
    au_b       = '0;
    au_sub     = 1'b0;
    head_we    = 1'b0;
    head_wdata = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_raddr  = '0;
    mem_wdata  = '0;
    case (state_q)
      pcpa_pkg::ST_IDLE: begin
        if (start) begin
          cpu_d  = CPU_W'(pcpa_pkg::cpu_mod(req_i.cpu, CPU_COUNT));
          addr_d = req_i.page_addr;
          own_d  = 1'b1;
          scan_d = '0;
          state_d = (req_i.command == pcpa_pkg::CMD_FREE) ? pcpa_pkg::ST_FREE_LO
                                                          : pcpa_pkg::ST_ALLOC_HEAD;
        end
      end
      pcpa_pkg::ST_FREE_LO: begin
        au_a   = {1'b0, addr_q};
        au_b   = {1'b0, start_q};
        au_sub = 1'b1;
        if (au_sum[ADDR_W] || (addr_q[PB_SHIFT-1:0] != '0)) begin
          res_d.status     = pcpa_pkg::RS_BAD_ADDR;
          res_d.alloc_addr = '0;
          strobe_d         = 1'b1;
          state_d          = pcpa_pkg::ST_IDLE;
        end else begin
          state_d = pcpa_pkg::ST_FREE_HI;
        end
      end
      pcpa_pkg::ST_FREE_HI: begin
        au_a   = {1'b0, addr_q};
        au_b   = {1'b0, stop_q};
        au_sub = 1'b1;
        if (!au_sum[ADDR_W]) begin
          res_d.status     = pcpa_pkg::RS_BAD_ADDR;
          res_d.alloc_addr = '0;
          strobe_d         = 1'b1;
          state_d          = pcpa_pkg::ST_IDLE;
        end else begin
          state_d = pcpa_pkg::ST_FREE_IDX;
        end
      end
      pcpa_pkg::ST_FREE_IDX: begin
        // aligned and at or above region start, so never below the rounded base
        au_a    = {1'b0, addr_q};
        au_b    = base_q;
        au_sub  = 1'b1;
        diff_d  = au_sum[ADDR_W-1:0];
        state_d = pcpa_pkg::ST_FREE_PUSH;
      end
      pcpa_pkg::ST_FREE_PUSH: begin
        res_d.alloc_addr = '0;
        strobe_d         = 1'b1;
        state_d          = pcpa_pkg::ST_IDLE;
        if (idx_full >= IDXF_W'(PAGE_COUNT)) begin
          res_d.status = pcpa_pkg::RS_BAD_ADDR;
        end else begin
          res_d.status = pcpa_pkg::RS_OK;
          mem_we       = 1'b1;
          mem_waddr    = idx_full[IDX_W-1:0];
          mem_wdata    = head_cur;
          head_we      = 1'b1;
          head_wdata   = LINK_W'(idx_full[IDX_W-1:0]) + LINK_W'(1);
        end
      end
      pcpa_pkg::ST_ALLOC_HEAD: begin
        if ((head_cur != '0) && (head_cur <= LINK_W'(PAGE_COUNT))) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(head_cur - LINK_W'(1));
          page_d    = IDX_W'(head_cur - LINK_W'(1));
          state_d   = pcpa_pkg::ST_ALLOC_READ;
        end else begin
          // a head beyond the page table counts as empty and is dropped
          head_we = (head_cur != '0);
          if (own_q) begin
            own_d  = 1'b0;
            scan_d = '0;
          end else if (scan_q == CPU_W'(CPU_COUNT - 1)) begin
            res_d.status     = pcpa_pkg::RS_NO_MEM;
            res_d.alloc_addr = '0;
            strobe_d         = 1'b1;
            state_d          = pcpa_pkg::ST_IDLE;
          end else begin
            scan_d = scan_q + CPU_W'(1);
          end
        end
      end
      pcpa_pkg::ST_ALLOC_READ: begin
        head_we          = 1'b1;
        head_wdata       = rdata_q;
        au_a             = base_q;
        au_b             = AU_W'(page_q) << PB_SHIFT;
        res_d.status     = pcpa_pkg::RS_OK;
        res_d.alloc_addr = au_sum[ADDR_W-1:0];
        strobe_d         = 1'b1;
        state_d          = pcpa_pkg::ST_IDLE;
      end
      default: begin
        state_d = pcpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcpa_pkg::ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_q  <= cpu_d;
    scan_q <= scan_d;
    own_q  <= own_d;
    addr_q <= addr_d;
    diff_q <= diff_d;
    page_q <= page_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= pcpa_pkg::DEF_REGION_START;
      stop_q  <= pcpa_pkg::DEF_REGION_STOP;
      base_q  <= pcpa_pkg::page_round_up(pcpa_pkg::DEF_REGION_START, PB_SHIFT);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcpa_pkg::CFG_REGION_START: begin
          start_q <= cfg_data_i;
          base_q  <= pcpa_pkg::page_round_up(cfg_data_i, PB_SHIFT);
        end
        pcpa_pkg::CFG_REGION_STOP: begin
          stop_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_q[i] <= '0;
      end
    end else if (head_we) begin
      head_q[sel] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= link_mem[mem_raddr];
    end
  end

  `ASSERT_CLK(a_base_aligned, base_q[PB_SHIFT-1:0] == '0, "page base not aligned")
  `ASSERT_CLK(a_strobe_idle, strobe_q |-> state_q == pcpa_pkg::ST_IDLE, "result outside idle")
  `ASSERT_CLK(a_strobe_single, strobe_q |=> !strobe_q, "two results back to back")
  `ASSERT_CLK(a_nomem_zero,
              strobe_q && res_q.status == pcpa_pkg::RS_NO_MEM |-> res_q.alloc_addr == '0,
              "address on out of memory")
  `ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !strobe_o && !busy, "activity in reset")

endmodule
